@@ rtl/gicp_pkg.sv @@
// ----------------------------------------------------------------------------
// gicp_pkg
// Shared constants for the greedy interval point cover block.
// ----------------------------------------------------------------------------
package gicp_pkg;

  // default geometry of the position bitmap
  localparam int POSITIONS_DEF = 65536;
  localparam int WORD_BITS_DEF = 64;

  // request and result field widths
  localparam int POS_W  = 16;
  localparam int NEED_W = 17;
  localparam int CNT_W  = 17;

  // running total saturates here
  localparam logic [CNT_W-1:0] TOTAL_MAX = 17'h1FFFF;

  // packed stream widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 40;

  // reciprocal scaling for position -> word index
  localparam int DIV_SH = 22;
  localparam int QUO_W  = 17;

endpackage

@@ rtl/gicp_ram.sv @@
// ----------------------------------------------------------------------------
// gicp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gicp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/greedy_interval_point_cover_top.sv @@
// ----------------------------------------------------------------------------
// greedy_interval_point_cover_top
// Greedy point cover over a word-organized bitmap of chosen positions.
// ----------------------------------------------------------------------------
// Each request names an interval [lo,hi] and a demand. The block counts the
// marked positions inside the interval, then marks the highest unmarked ones
// until the demand is met (or the interval is full) and returns the number
// newly marked and the saturating running total. The bitmap lives in one RAM
// of WORDS = ceil(POSITIONS/WORD_BITS) words. After reset, and before any
// request with start set in tuser, a clearing pass writes every word to zero
// (no request is taken meanwhile). A request then walks words upward while
// counting (up to the words covering the interval), then downward while
// marking, and spends up to WORD_BITS single-bit steps on the last, partly
// marked word; every word visit is a RAM read state followed by an
// evaluate/write state. One request is in flight at a time; the result sits
// in an output register so the next request is taken while it waits.
module greedy_interval_point_cover_top
  import gicp_pkg::*;
#(
  parameter int POSITIONS = POSITIONS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // lo[15:0], hi[31:16], need[48:32]
  input  logic                   in_tuser,   // start_req[0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // added[16:0], total[33:17]
);

  localparam int WORDS   = (POSITIONS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BW      = $clog2(WORD_BITS);
  localparam int CW      = $clog2(WORD_BITS + 1);
  localparam int HI_MAX  = (POSITIONS - 1 < 65535) ? POSITIONS - 1 : 65535;
  localparam int RECIP   = (1 << DIV_SH) / WORD_BITS;
  localparam int PROD_W  = DIV_SH + QUO_W;
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
  localparam logic [BW-1:0] TOP_BIT   = BW'(WORD_BITS - 1);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIV, S_FIX, S_CNT_RD, S_CNT_ACC,
    S_MK_RD, S_MK_EVAL, S_MK_BIT, S_DONE
  } state_t;

  state_t state_r;

  // request fields
  logic [POS_W-1:0]  in_lo, in_hi, hi_clip;
  logic [NEED_W-1:0] in_need;

  // per-request registers
  logic [POS_W-1:0]  lo_r, hi_r;
  logic              empty_r, pend_r;
  logic [QUO_W-1:0]  lo_qe_r, hi_qe_r;
  logic [AW-1:0]     lo_q_r, hi_q_r, w_r, clr_addr_r;
  logic [BW-1:0]     lo_b_r, hi_b_r, bit_r;
  logic [NEED_W-1:0] rem_r;
  logic [CNT_W-1:0]  added_r, total_r;
  logic [WORD_BITS-1:0] word_r;

  // output register
  logic              out_valid_r;
  logic [CNT_W-1:0]  out_added_r, out_total_r;

  // RAM port
  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  // datapath
  logic [PROD_W-1:0]    lo_prod, hi_prod;
  logic [QUO_W-1:0]     lo_rem, hi_rem;
  logic                 lo_fix, hi_fix;
  logic [BW-1:0]        lb, hb;
  logic [WORD_BITS-1:0] mask, have_bits, free_bits, bit_sel;
  logic [CW-1:0]        pc, fc;
  logic [CNT_W:0]       tot_sum, tot_inc;
  logic [CNT_W-1:0]     tot_sat, tot_sat1;
  logic                 mark_all;

  assign in_lo   = in_tdata[15:0];
  assign in_hi   = in_tdata[31:16];
  assign in_need = in_tdata[48:32];

  // clip hi to the last existing position
  assign hi_clip = (int'(in_hi) > HI_MAX) ? POS_W'(HI_MAX) : in_hi;

  // word index estimate by reciprocal, low by at most one
  assign lo_prod = PROD_W'(lo_r) * PROD_W'(RECIP);
  assign hi_prod = PROD_W'(hi_r) * PROD_W'(RECIP);

  // remainder and one-step correction
  assign lo_rem = QUO_W'(lo_r) - QUO_W'(lo_qe_r * QUO_W'(WORD_BITS));
  assign hi_rem = QUO_W'(hi_r) - QUO_W'(hi_qe_r * QUO_W'(WORD_BITS));
  assign lo_fix = (lo_rem >= QUO_W'(WORD_BITS));
  assign hi_fix = (hi_rem >= QUO_W'(WORD_BITS));

  // in-interval bit mask for the current word
  assign lb   = (w_r == lo_q_r) ? lo_b_r : '0;
  assign hb   = (w_r == hi_q_r) ? hi_b_r : TOP_BIT;
  assign mask = ({WORD_BITS{1'b1}} << lb) & ({WORD_BITS{1'b1}} >> (TOP_BIT - hb));

  assign have_bits = ram_rdata & mask;
  assign free_bits = ~ram_rdata & mask;
  assign pc        = CW'($countones(have_bits));
  assign fc        = CW'($countones(free_bits));
  assign mark_all  = (NEED_W'(fc) <= rem_r);

  // saturating total updates
  assign tot_sum  = {1'b0, total_r} + (CNT_W + 1)'(fc);
  assign tot_inc  = {1'b0, total_r} + (CNT_W + 1)'(1);
  assign tot_sat  = (tot_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : tot_sum[CNT_W-1:0];
  assign tot_sat1 = (tot_inc > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : tot_inc[CNT_W-1:0];

  assign bit_sel = WORD_BITS'(1) << bit_r;

  // RAM control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = w_r;
    ram_wdata = ram_rdata | free_bits;
    ram_re    = (state_r == S_CNT_RD) || (state_r == S_MK_RD);
    unique case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      S_MK_EVAL: begin
        ram_we = mark_all;
      end
      S_MK_BIT: begin
        ram_we    = !word_r[bit_r] && (rem_r == NEED_W'(1));
        ram_wdata = word_r | bit_sel;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // sequencer, per-request registers and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_addr_r  <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= '0;
    end else begin
      // in S_DONE the output register is reloaded or kept full
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == LAST_WORD) begin
            clr_addr_r <= '0;
            pend_r     <= 1'b0;
            state_r    <= pend_r ? S_DIV : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_tvalid) begin
            lo_r    <= in_lo;
            hi_r    <= hi_clip;
            rem_r   <= in_need;
            added_r <= '0;
            empty_r <= (in_lo > hi_clip);
            if (in_tuser) begin
              total_r <= '0;
              pend_r  <= 1'b1;
              state_r <= S_CLR;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          lo_qe_r <= lo_prod[PROD_W-1 -: QUO_W];
          hi_qe_r <= hi_prod[PROD_W-1 -: QUO_W];
          state_r <= S_FIX;
        end
        S_FIX: begin
          lo_q_r  <= AW'(lo_fix ? lo_qe_r + QUO_W'(1) : lo_qe_r);
          hi_q_r  <= AW'(hi_fix ? hi_qe_r + QUO_W'(1) : hi_qe_r);
          lo_b_r  <= BW'(lo_fix ? lo_rem - QUO_W'(WORD_BITS) : lo_rem);
          hi_b_r  <= BW'(hi_fix ? hi_rem - QUO_W'(WORD_BITS) : hi_rem);
          w_r     <= AW'(lo_fix ? lo_qe_r + QUO_W'(1) : lo_qe_r);
          state_r <= (empty_r || rem_r == '0) ? S_DONE : S_CNT_RD;
        end
        S_CNT_RD: begin
          state_r <= S_CNT_ACC;
        end
        S_CNT_ACC: begin
          // count marked positions, stop early once the demand is met
          if (rem_r > NEED_W'(pc)) begin
            rem_r <= rem_r - NEED_W'(pc);
            if (w_r == hi_q_r) begin
              state_r <= S_MK_RD;
            end else begin
              w_r     <= w_r + AW'(1);
              state_r <= S_CNT_RD;
            end
          end else begin
            rem_r   <= '0;
            state_r <= S_DONE;
          end
        end
        S_MK_RD: begin
          state_r <= S_MK_EVAL;
        end
        S_MK_EVAL: begin
          if (mark_all) begin
            // whole free part of this word fits the demand
            rem_r   <= rem_r - NEED_W'(fc);
            added_r <= added_r + CNT_W'(fc);
            total_r <= tot_sat;
            if (rem_r == NEED_W'(fc) || w_r == lo_q_r) begin
              state_r <= S_DONE;
            end else begin
              w_r     <= w_r - AW'(1);
              state_r <= S_MK_RD;
            end
          end else begin
            // partial word: walk down one bit at a time
            word_r  <= ram_rdata;
            bit_r   <= hb;
            state_r <= S_MK_BIT;
          end
        end
        S_MK_BIT: begin
          if (!word_r[bit_r]) begin
            word_r  <= word_r | bit_sel;
            rem_r   <= rem_r - NEED_W'(1);
            added_r <= added_r + CNT_W'(1);
            total_r <= tot_sat1;
            if (rem_r == NEED_W'(1)) begin
              state_r <= S_DONE;
            end
          end
          bit_r <= bit_r - BW'(1);
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_added_r <= added_r;
            out_total_r <= total_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - 2 * CNT_W)'(0), out_total_r, out_added_r};

  // bitmap store
  gicp_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(WORDS),
    .AW   (AW)
  ) u_mark_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(w_r),
    .rdata(ram_rdata)
  );

endmodule
